### rtl/glb_container_validator_core_assert.svh
// assertion macros for the glb container validator rtl
// no dependencies; included by the top level
`ifndef GLB_CONTAINER_VALIDATOR_CORE_ASSERT_SVH
`define GLB_CONTAINER_VALIDATOR_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define GLB_CV_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define GLB_CV_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/glb_cv_pkg.sv
// types and constants for the glb container validator
// no dependencies; used by every rtl module of the block
`default_nettype none

package glb_cv_pkg;

  typedef enum logic [1:0] {
    PH_HDR,
    PH_CHDR,
    PH_DATA,
    PH_DONE
  } phase_e;

  typedef enum logic [3:0] {
    ST_OK         = 4'd0,
    ST_SMALL      = 4'd1,
    ST_MAGIC      = 4'd2,
    ST_VERSION    = 4'd3,
    ST_LEN_BIG    = 4'd4,
    ST_LEN_SHORT  = 4'd5,
    ST_UNALIGNED  = 4'd6,
    ST_BOUNDS     = 4'd7,
    ST_JSON_POS   = 4'd8,
    ST_BIN_POS    = 4'd9,
    ST_TYPE       = 4'd10,
    ST_NO_JSON    = 4'd11,
    ST_EMPTY_JSON = 4'd12
  } status_e;

  localparam logic [31:0] HDR_MAGIC     = 32'h4654_6C67;
  localparam logic [31:0] GLB_JSON_TYPE = 32'h4E4F_534A;
  localparam logic [31:0] GLB_BIN_TYPE  = 32'h004E_4942;
  localparam logic [31:0] GLB_VERSION   = 32'd2;
  localparam logic [31:0] HDR_BYTES     = 32'd12;
  localparam logic [31:0] CHDR_BYTES    = 32'd8;
  localparam logic [31:0] FIRST_CHDR_END = 32'd20;

  // header byte positions where a word completes
  localparam logic [31:0] POS_MAGIC   = 32'd3;
  localparam logic [31:0] POS_VERSION = 32'd7;
  localparam logic [31:0] POS_TOTAL   = 32'd11;

  // offsets inside a chunk header where a word completes
  localparam logic [2:0] SUB_LEN  = 3'd3;
  localparam logic [2:0] SUB_TYPE = 3'd7;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       last;
  } beat_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] version;
    logic [31:0] total_length;
    logic [31:0] json_offset;
    logic [31:0] json_length;
    logic        has_bin;
    logic [31:0] bin_offset;
    logic [31:0] bin_length;
  } result_t;

endpackage

`default_nettype wire

### rtl/glb_cv_in_reg.sv
// input register of the glb container validator, holds one beat
// depends on glb_cv_pkg
`default_nettype none

module glb_cv_in_reg (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire glb_cv_pkg::beat_t in_beat_i,
  output logic                   in_stall_o,
  input  wire logic              adv_i,
  output logic                   valid_o,
  output glb_cv_pkg::beat_t      beat_o
);

  logic              valid_q, valid_d;
  glb_cv_pkg::beat_t beat_q;
  logic              load;

  assign in_stall_o = valid_q & ~adv_i;
  assign load       = in_valid_i & ~in_stall_o;
  assign valid_d    = load | (valid_q & ~adv_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      beat_q <= in_beat_i;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

`default_nettype wire

### rtl/glb_cv_parse.sv
// parse state of the glb container validator: header and chunk walk
// one beat per step; depends on glb_cv_pkg
`default_nettype none

module glb_cv_parse (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  wire glb_cv_pkg::beat_t beat_i,
  input  wire logic [31:0]       file_size_i,
  output glb_cv_pkg::result_t    result_o
);

  glb_cv_pkg::phase_e  phase_q, phase_d;
  glb_cv_pkg::status_e err_q, err_d;
  logic [31:0] pos_q, pos_d;
  logic [31:0] word_q, word_d;
  logic [31:0] total_q, total_d;
  logic [31:0] version_q, version_d;
  logic [31:0] len_q, len_d;
  logic [31:0] ce_q, ce_d;
  logic [1:0]  cs_q, cs_d;
  logic [31:0] json_off_q, json_off_d;
  logic [31:0] json_len_q, json_len_d;
  logic [31:0] bin_off_q, bin_off_d;
  logic [31:0] bin_len_q, bin_len_d;
  logic        bin_seen_q, bin_seen_d;

  logic [2:0]  sub;
  logic [32:0] data_off;
  logic [33:0] chunk_end;
  logic        fit_zero;
  logic        fit_data;
  logic        data_hit;
  logic        take;
  glb_cv_pkg::status_e st;

  assign sub       = pos_q[2:0] - ce_q[2:0];
  assign data_off  = {1'b0, ce_q} + {1'b0, glb_cv_pkg::CHDR_BYTES};
  assign chunk_end = {1'b0, data_off} + {2'b0, len_q};
  // zero-length chunk: next header would start at data_off
  assign fit_zero  = ({1'b0, data_off} + {2'b0, glb_cv_pkg::CHDR_BYTES}) <= {2'b0, total_q};
  assign fit_data  = ({1'b0, ce_q} + {1'b0, glb_cv_pkg::CHDR_BYTES}) <= {1'b0, total_q};
  assign data_hit  = ({1'b0, pos_q} + 33'd1) == {1'b0, ce_q};

  always_comb begin
    phase_d    = phase_q;
    err_d      = err_q;
    pos_d      = (pos_q == '1) ? pos_q : pos_q + 32'd1;
    word_d     = {beat_i.byte_in, word_q[31:8]};
    total_d    = total_q;
    version_d  = version_q;
    len_d      = len_q;
    ce_d       = ce_q;
    cs_d       = cs_q;
    json_off_d = json_off_q;
    json_len_d = json_len_q;
    bin_off_d  = bin_off_q;
    bin_len_d  = bin_len_q;
    bin_seen_d = bin_seen_q;
    take       = 1'b0;

    if (err_q == glb_cv_pkg::ST_OK) begin
      case (phase_q)
        glb_cv_pkg::PH_HDR: begin
          if (pos_q == 32'd0 && file_size_i < glb_cv_pkg::HDR_BYTES) begin
            err_d   = glb_cv_pkg::ST_SMALL;
            phase_d = glb_cv_pkg::PH_DONE;
          end else if (pos_q == glb_cv_pkg::POS_MAGIC && word_d != glb_cv_pkg::HDR_MAGIC) begin
            err_d   = glb_cv_pkg::ST_MAGIC;
            phase_d = glb_cv_pkg::PH_DONE;
          end else if (pos_q == glb_cv_pkg::POS_VERSION) begin
            version_d = word_d;
            if (word_d != glb_cv_pkg::GLB_VERSION) begin
              err_d   = glb_cv_pkg::ST_VERSION;
              phase_d = glb_cv_pkg::PH_DONE;
            end
          end else if (pos_q == glb_cv_pkg::POS_TOTAL) begin
            total_d = word_d;
            if (word_d > file_size_i) begin
              err_d   = glb_cv_pkg::ST_LEN_BIG;
              phase_d = glb_cv_pkg::PH_DONE;
            end else if (word_d < glb_cv_pkg::HDR_BYTES) begin
              err_d   = glb_cv_pkg::ST_LEN_SHORT;
              phase_d = glb_cv_pkg::PH_DONE;
            end else begin
              ce_d    = glb_cv_pkg::HDR_BYTES;
              phase_d = (glb_cv_pkg::FIRST_CHDR_END <= word_d) ? glb_cv_pkg::PH_CHDR
                                                               : glb_cv_pkg::PH_DONE;
            end
          end
        end
        glb_cv_pkg::PH_CHDR: begin
          if (sub == glb_cv_pkg::SUB_LEN) begin
            len_d = word_d;
          end else if (sub == glb_cv_pkg::SUB_TYPE) begin
            if (len_q[1:0] != 2'b00) begin
              err_d   = glb_cv_pkg::ST_UNALIGNED;
              phase_d = glb_cv_pkg::PH_DONE;
            end else if (chunk_end > {2'b0, total_q}) begin
              err_d   = glb_cv_pkg::ST_BOUNDS;
              phase_d = glb_cv_pkg::PH_DONE;
            end else if (word_d == glb_cv_pkg::GLB_JSON_TYPE) begin
              if (cs_q != 2'd0) begin
                err_d   = glb_cv_pkg::ST_JSON_POS;
                phase_d = glb_cv_pkg::PH_DONE;
              end else begin
                json_off_d = data_off[31:0];
                json_len_d = len_q;
                take       = 1'b1;
              end
            end else if (word_d == glb_cv_pkg::GLB_BIN_TYPE) begin
              if (cs_q != 2'd1) begin
                err_d   = glb_cv_pkg::ST_BIN_POS;
                phase_d = glb_cv_pkg::PH_DONE;
              end else begin
                bin_off_d  = data_off[31:0];
                bin_len_d  = len_q;
                bin_seen_d = 1'b1;
                take       = 1'b1;
              end
            end else begin
              err_d   = glb_cv_pkg::ST_TYPE;
              phase_d = glb_cv_pkg::PH_DONE;
            end
            if (take) begin
              cs_d = (cs_q == 2'd3) ? cs_q : cs_q + 2'd1;
              // bounds check above keeps the end within 32 bits
              ce_d = chunk_end[31:0];
              if (len_q == 32'd0) begin
                phase_d = fit_zero ? glb_cv_pkg::PH_CHDR : glb_cv_pkg::PH_DONE;
              end else begin
                phase_d = glb_cv_pkg::PH_DATA;
              end
            end
          end
        end
        glb_cv_pkg::PH_DATA: begin
          if (data_hit) begin
            phase_d = fit_data ? glb_cv_pkg::PH_CHDR : glb_cv_pkg::PH_DONE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // verdict on the final beat, from the state after that beat
  always_comb begin
    st = err_d;
    if (st == glb_cv_pkg::ST_OK) begin
      if (phase_d == glb_cv_pkg::PH_HDR) begin
        st = glb_cv_pkg::ST_SMALL;
      end else if (phase_d != glb_cv_pkg::PH_DONE) begin
        st = glb_cv_pkg::ST_BOUNDS;
      end else if (cs_d == 2'd0) begin
        st = glb_cv_pkg::ST_NO_JSON;
      end else if (json_len_d == 32'd0) begin
        st = glb_cv_pkg::ST_EMPTY_JSON;
      end
    end
    result_o.status = st;
    if (st inside {[glb_cv_pkg::ST_SMALL : glb_cv_pkg::ST_LEN_SHORT]}) begin
      result_o.version      = '0;
      result_o.total_length = '0;
    end else begin
      result_o.version      = version_d;
      result_o.total_length = total_d;
    end
    result_o.json_offset = json_off_d;
    result_o.json_length = json_len_d;
    result_o.has_bin     = bin_seen_d;
    result_o.bin_offset  = bin_off_d;
    result_o.bin_length  = bin_len_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= glb_cv_pkg::PH_HDR;
      err_q      <= glb_cv_pkg::ST_OK;
      pos_q      <= '0;
      word_q     <= '0;
      total_q    <= '0;
      version_q  <= '0;
      len_q      <= '0;
      ce_q       <= '0;
      cs_q       <= '0;
      json_off_q <= '0;
      json_len_q <= '0;
      bin_off_q  <= '0;
      bin_len_q  <= '0;
      bin_seen_q <= 1'b0;
    end else if (step_i && beat_i.last) begin
      // stream finished: back to the start for the next file
      phase_q    <= glb_cv_pkg::PH_HDR;
      err_q      <= glb_cv_pkg::ST_OK;
      pos_q      <= '0;
      word_q     <= '0;
      total_q    <= '0;
      version_q  <= '0;
      len_q      <= '0;
      ce_q       <= '0;
      cs_q       <= '0;
      json_off_q <= '0;
      json_len_q <= '0;
      bin_off_q  <= '0;
      bin_len_q  <= '0;
      bin_seen_q <= 1'b0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      err_q      <= err_d;
      pos_q      <= pos_d;
      word_q     <= word_d;
      total_q    <= total_d;
      version_q  <= version_d;
      len_q      <= len_d;
      ce_q       <= ce_d;
      cs_q       <= cs_d;
      json_off_q <= json_off_d;
      json_len_q <= json_len_d;
      bin_off_q  <= bin_off_d;
      bin_len_q  <= bin_len_d;
      bin_seen_q <= bin_seen_d;
    end
  end

endmodule

`default_nettype wire

### rtl/glb_cv_out_reg.sv
// result register of the glb container validator
// depends on glb_cv_pkg
`default_nettype none

module glb_cv_out_reg (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                load_i,
  input  wire glb_cv_pkg::result_t result_i,
  input  wire logic                out_stall_i,
  output logic                     out_valid_o,
  output glb_cv_pkg::result_t      result_o
);

  logic                valid_q, valid_d;
  glb_cv_pkg::result_t result_q;

  // load is only raised when the register is free or being emptied
  assign valid_d = load_i | (valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

`default_nettype wire

### rtl/glb_container_validator_core.sv
// glb container validator top level: input register, parse step, result register
// result path: the final beat is registered in the input register, then its result in the result register
// throughput: one beat per cycle; the input stalls only when a final beat waits
// behind a result that is still held by out_stall_i
// reset: all parse state and file_size clear to zero, no beat or result pending
// depends on glb_cv_pkg, glb_cv_in_reg, glb_cv_parse, glb_cv_out_reg
`default_nettype none

`include "glb_container_validator_core_assert.svh"

module glb_container_validator_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  byte_in_i,
  input  wire logic        last_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [3:0]       status_o,
  output logic [31:0]      version_o,
  output logic [31:0]      total_length_o,
  output logic [31:0]      json_offset_o,
  output logic [31:0]      json_length_o,
  output logic             has_bin_o,
  output logic [31:0]      bin_offset_o,
  output logic [31:0]      bin_length_o
);

  logic [31:0]         file_size_q;
  glb_cv_pkg::beat_t   in_beat;
  glb_cv_pkg::beat_t   s1_beat;
  logic                s1_valid;
  logic                adv;
  logic                step;
  glb_cv_pkg::result_t res_next;
  glb_cv_pkg::result_t res_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      file_size_q <= '0;
    end else if (cfg_we_i) begin
      file_size_q <= cfg_wdata_i;
    end
  end

  assign in_beat.byte_in = byte_in_i;
  assign in_beat.last    = last_i;

  // a final beat must wait while the previous result is still stalled
  assign adv  = ~(s1_beat.last & out_valid_o & out_stall_i);
  assign step = s1_valid & adv;

  glb_cv_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_beat_i  (in_beat),
    .in_stall_o (in_stall_o),
    .adv_i      (adv),
    .valid_o    (s1_valid),
    .beat_o     (s1_beat)
  );

  glb_cv_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .beat_i      (s1_beat),
    .file_size_i (file_size_q),
    .result_o    (res_next)
  );

  glb_cv_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step & s1_beat.last),
    .result_i    (res_next),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .result_o    (res_out)
  );

  assign status_o       = res_out.status;
  assign version_o      = res_out.version;
  assign total_length_o = res_out.total_length;
  assign json_offset_o  = res_out.json_offset;
  assign json_length_o  = res_out.json_length;
  assign has_bin_o      = res_out.has_bin;
  assign bin_offset_o   = res_out.bin_offset;
  assign bin_length_o   = res_out.bin_length;

  `GLB_CV_ASSERT_IMP(a_stall_cause, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i && s1_beat.last, "input stalled without a blocked result")
  `GLB_CV_ASSERT_IMP(a_status_range, clk_i, rst_ni, out_valid_o, status_o <= glb_cv_pkg::ST_EMPTY_JSON, "status code out of range")
  `GLB_CV_ASSERT_IMP(a_ok_json, clk_i, rst_ni, out_valid_o && status_o == glb_cv_pkg::ST_OK, json_length_o != 32'd0 && json_offset_o == glb_cv_pkg::FIRST_CHDR_END && version_o == glb_cv_pkg::GLB_VERSION, "ok result without a valid json chunk")
  `GLB_CV_ASSERT_IMP(a_no_bin, clk_i, rst_ni, out_valid_o && !has_bin_o, bin_length_o == 32'd0 && bin_offset_o == 32'd0, "bin fields set without a bin chunk")
  `GLB_CV_ASSERT_NXT(a_last_result, clk_i, rst_ni, step && s1_beat.last, out_valid_o, "final beat gave no result")

endmodule

`default_nettype wire
